// ===== src/b58u_pkg.sv =====
`default_nettype none
package b58u_pkg;

  localparam int TEXT_SLOTS = 8;
  localparam int DIGITS     = 6;
  localparam int RADIX      = 58;
  localparam int QSHIFT     = 37;
  localparam logic [31:0] RECIP = 32'((64'd1 << QSHIFT) / RADIX);

  typedef logic [6:0] char_t;
  typedef char_t [DIGITS-1:0] text_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIX
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic char_t digit_char(input logic [5:0] d);
    char_t c;
    priority if (d < 6'd9) begin
      c = 7'(7'h31 + 7'(d));
    end else if (d < 6'd20) begin
      c = 7'(7'h61 + 7'(d - 6'd9));
    end else if (d < 6'd34) begin
      c = 7'(7'h6d + 7'(d - 6'd20));
    end else if (d < 6'd42) begin
      c = 7'(7'h41 + 7'(d - 6'd34));
    end else if (d < 6'd47) begin
      c = 7'(7'h4a + 7'(d - 6'd42));
    end else begin
      c = 7'(7'h50 + 7'(d - 6'd47));
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/b58u_ctrl.sv =====
`default_nettype none
module b58u_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire b58u_pkg::stat_t stat,
  output b58u_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  b58u_pkg::state_t state, state_next;
  logic done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b58u_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      b58u_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = b58u_pkg::S_MUL;
        end
      end
      b58u_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = b58u_pkg::S_FIX;
      end
      b58u_pkg::S_FIX: begin
        cmd.fix = 1'b1;
        if (stat.last) begin
          done_next  = 1'b1;
          state_next = b58u_pkg::S_IDLE;
        end else begin
          state_next = b58u_pkg::S_MUL;
        end
      end
      default: state_next = b58u_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != b58u_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== src/b58u_dp.sv =====
`default_nettype none
module b58u_dp (
  input  wire logic           clk,
  input  wire logic [31:0]    uid_value,
  input  wire b58u_pkg::cmd_t cmd,
  output b58u_pkg::stat_t     stat,
  output b58u_pkg::text_t     text
);

  logic [31:0] value;
  logic [26:0] q_est;
  logic [63:0] prod;
  logic [31:0] q58;
  logic [31:0] r_raw;
  logic        r_big;
  logic [26:0] q_fix;
  logic [5:0]  r_fix;

  assign prod = value * b58u_pkg::RECIP;

  // quotient estimate is low by at most one
  always_comb begin
    q58   = {q_est, 5'd0} + {1'b0, q_est, 4'd0} + {2'd0, q_est, 3'd0} + {4'd0, q_est, 1'b0};
    r_raw = value - q58;
    r_big = (r_raw[6:0] >= 7'(b58u_pkg::RADIX));
    q_fix = q_est + 27'(r_big);
    r_fix = r_big ? 6'(r_raw[6:0] - 7'(b58u_pkg::RADIX)) : r_raw[5:0];
  end

  assign stat.last = (q_fix == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= uid_value;
      text  <= '0;
    end
    if (cmd.mul) begin
      q_est <= prod[63:b58u_pkg::QSHIFT];
    end
    if (cmd.fix) begin
      value <= {5'd0, q_fix};
      // newest digit is the most significant so far
      text  <= {text[b58u_pkg::DIGITS-2:0], b58u_pkg::digit_char(r_fix)};
    end
  end

endmodule
`default_nettype wire

// ===== src/base58_uid_to_text.sv =====
`default_nettype none
// base-58 text of a 32-bit identifier, most significant character first
//
// input: raise start with uid_value; the word is taken at a rising edge
// where start is high and busy is low. busy stays high while the digits
// are worked out.
// output: done is high for exactly one cycle with char_0 .. char_7 valid;
// the receiver cannot stall, so the word must be taken in that cycle.
// slots past the last digit are 0; char_6 and char_7 are always 0.
//
// steps: each digit takes a reciprocal multiply, then a correcting
// subtract; an identifier has 1 to 6 digits, and the block works on one
// identifier at a time, taking no new word until done. busy drops in
// the cycle that done is shown, so a new word may be taken then.
// reset: synchronous; clears the controller, busy and done go low.
module base58_uid_to_text (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] uid_value,
  output logic             busy,
  output logic             done,
  output logic [6:0]       char_0,
  output logic [6:0]       char_1,
  output logic [6:0]       char_2,
  output logic [6:0]       char_3,
  output logic [6:0]       char_4,
  output logic [6:0]       char_5,
  output logic             char_6,
  output logic             char_7
);

  b58u_pkg::cmd_t  cmd;
  b58u_pkg::stat_t stat;
  b58u_pkg::text_t text;

  b58u_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  b58u_dp u_dp (
    .clk       (clk),
    .uid_value (uid_value),
    .cmd       (cmd),
    .stat      (stat),
    .text      (text)
  );

  assign char_0 = (b58u_pkg::TEXT_SLOTS > 0) ? text[0] : '0;
  assign char_1 = (b58u_pkg::TEXT_SLOTS > 1) ? text[1] : '0;
  assign char_2 = (b58u_pkg::TEXT_SLOTS > 2) ? text[2] : '0;
  assign char_3 = (b58u_pkg::TEXT_SLOTS > 3) ? text[3] : '0;
  assign char_4 = (b58u_pkg::TEXT_SLOTS > 4) ? text[4] : '0;
  assign char_5 = (b58u_pkg::TEXT_SLOTS > 5) ? text[5] : '0;
  assign char_6 = 1'b0;
  assign char_7 = 1'b0;

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("word taken but block not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_has_char: assert property (@(posedge clk) disable iff (rst)
    done |-> (char_0 != 7'd0))
    else $error("result without a leading character");

endmodule
`default_nettype wire

// ===== tb/base58_uid_to_text_test.sv =====
`timescale 1ns / 1ps

typedef logic [7:0][6:0] uid_text_t;

typedef struct {
  logic [31:0] uid;
  uid_text_t   text;
} uid_text_entry_t;

class text_board;
  uid_text_entry_t pending_text[$];
  int              failures;
  string           letters;

  function new();
    failures = 0;
    letters  = "123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";
  endfunction

  function int pending();
    return pending_text.size();
  endfunction

  // base-58 digits, most significant first, zero slots after the last one
  function uid_text_t render_text(logic [31:0] v);
    logic [5:0]  rev [0:5];
    logic [31:0] rest;
    uid_text_t   t;
    int          n;
    rest = v;
    n    = 0;
    t    = '0;
    do begin
      rev[n] = 6'(rest % 32'd58);
      rest   = rest / 32'd58;
      n++;
    end while (rest != 0 && n < 6);
    for (int j = 0; j < 8; j++) begin
      if (j < n && j < b58u_pkg::TEXT_SLOTS) begin
        t[j] = 7'(letters[rev[n-1-j]]);
      end
    end
    t[6] = {6'b0, t[6][0]};
    t[7] = {6'b0, t[7][0]};
    return t;
  endfunction

  function void note_uid(logic [31:0] v);
    uid_text_entry_t e;
    e.uid  = v;
    e.text = render_text(v);
    pending_text.push_back(e);
  endfunction

  function void report(string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function void check_text(uid_text_t got);
    uid_text_entry_t e;
    if (pending_text.size() == 0) begin
      report($sformatf("unexpected word: %h", got));
      return;
    end
    e = pending_text.pop_front();
    for (int j = 0; j < 8; j++) begin
      if (got[j] !== e.text[j]) begin
        report($sformatf("uid %h char_%0d: expected %h, got %h", e.uid, j, e.text[j], got[j]));
      end
    end
  endfunction
endclass

module base58_uid_to_text_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS       = 1350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] uid_value = '0;
  logic        busy;
  logic        done;
  logic [6:0]  char_0, char_1, char_2, char_3, char_4, char_5;
  logic        char_6, char_7;

  text_board board;
  int        cycle_count = 0;

  base58_uid_to_text i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .uid_value (uid_value),
    .busy      (busy),
    .done      (done),
    .char_0    (char_0),
    .char_1    (char_1),
    .char_2    (char_2),
    .char_3    (char_3),
    .char_4    (char_4),
    .char_5    (char_5),
    .char_6    (char_6),
    .char_7    (char_7)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base58_uid_to_text_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_text({{6'b0, char_7}, {6'b0, char_6},
                        char_5, char_4, char_3, char_2, char_1, char_0});
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_uid();
    longint lo;
    longint hi;
    longint acc;
    int     n;
    int     d;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        n  = $urandom_range(1, 6);
        lo = (n == 1) ? 0 : 58 ** (n - 1);
        hi = (n == 6) ? 64'hFFFF_FFFF : 58 ** n - 1;
        acc = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return 32'(acc);
      end
      2: begin
        // digits pushed to their extremes
        n   = $urandom_range(1, 6);
        acc = 0;
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 2))
            0: d = 0;
            1: d = 57;
            default: d = $urandom_range(0, 57);
          endcase
          if (k == 0 && d == 0) begin
            d = $urandom_range(1, 57);
          end
          acc = acc * 58 + d;
        end
        return 32'(acc);
      end
      default: return $urandom_range(0, 3400);
    endcase
  endfunction

  task automatic send_uid(input logic [31:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    uid_value <= v;
    do @(posedge clk); while (busy);
    board.note_uid(v);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  logic [31:0] directed [$] = '{
    32'd0, 32'd1, 32'd57, 32'd58, 32'd59, 32'd3363, 32'd3364,
    32'd195111, 32'd195112, 32'd11316495, 32'd11316496,
    32'd656356767, 32'd656356768, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd8, 32'd9,
    32'd33, 32'd34, 32'd46, 32'd47
  };

  initial begin
    bit quiet;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_uid(directed[i], pick_gap(1'b0));
    end

    quiet = 1'b0;
    for (int i = 0; i < ITEMS; i++) begin
      if (i % 150 == 0) begin
        quiet = ~quiet;
      end
      if (i == 700) begin
        drain();
      end
      send_uid(random_uid(), pick_gap(quiet));
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("base58_uid_to_text_test OK");
    end else begin
      $display("base58_uid_to_text_test NOT OK");
    end
    $finish;
  end

endmodule
